>>> sv/frame_rotate_flip_engine_top_macros.svh
// Assertion macros for the frame rotate/flip engine checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef FRAME_ROTATE_FLIP_ENGINE_TOP_MACROS_SVH
`define FRAME_ROTATE_FLIP_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/frfe_pkg.sv
// Shared types and constants of the frame rotate/flip engine.
// No dependencies; used by the top level and its checker.
package frfe_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Reset value of both frame dimensions, before clamping to the maximum.
  localparam int unsigned CFG_DIM_RESET = 256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Input transaction kinds.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_COPY      = 3'd0,
    MODE_GRAY      = 3'd1,
    MODE_NEGATIVE  = 3'd2,
    MODE_FLIP      = 3'd3,
    MODE_ROT_CW    = 3'd4,
    MODE_ROT_CCW   = 3'd5,
    MODE_MIRROR_LR = 3'd6,
    MODE_MIRROR_TB = 3'd7
  } mode_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // Fixed-point luma weights; they sum to 65536, so the sum fits in 24 bits.
  localparam int unsigned GRAY_SUM_W = 24;
  localparam logic [15:0] GRAY_R_COEF = 16'd19595;
  localparam logic [15:0] GRAY_G_COEF = 16'd38470;
  localparam logic [15:0] GRAY_B_COEF = 16'd7471;

endpackage

>>> sv/frame_rotate_flip_engine_top.sv
// Frame rotate/flip engine: loads one RGB frame in raster order, reads it back transformed.
// Reads reach out_valid_o through the read pipeline; one transaction per cycle when not stalled.
// Loads write the frame memory at acceptance; reads pass a 4-stage pipeline around its read port.
// After the last pixel of a frame, loads are held, also through any output stall, until earlier
// reads have read. Reset clears counters, positions and the pipeline, sets mode copy and
// 256x256 (clamped); the frame memory is not cleared.
module frame_rotate_flip_engine_top
  import frfe_pkg::*;
#(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [CHAN_W-1:0]     in_red_i,
  input  logic [CHAN_W-1:0]     in_green_i,
  input  logic [CHAN_W-1:0]     in_blue_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAN_W-1:0]     out_red_o,
  output logic [CHAN_W-1:0]     out_green_o,
  output logic [CHAN_W-1:0]     out_blue_o,
  output logic                  last_pixel_o
);

  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned POS_W   = $clog2(MAX_DIM);
  localparam int unsigned PROD_W  = 2 * DIM_W;
  localparam int unsigned RST_DIM = (CFG_DIM_RESET > MAX_DIM) ? MAX_DIM : CFG_DIM_RESET;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers; dimensions are stored clamped, with their product.
  // ---------------------------------------------------------------------------
  mode_e              mode_q;
  logic [DIM_W-1:0]   w_q, h_q;
  logic [CNT_W-1:0]   total_q;
  logic               cfg_we;
  logic [DIM_W-1:0]   w_new, h_new;
  logic [PROD_W-1:0]  total_prod;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    w_new      = (cfg_index_i == CFG_WIDTH)  ? clamp_dim(cfg_data_i) : w_q;
    h_new      = (cfg_index_i == CFG_HEIGHT) ? clamp_dim(cfg_data_i) : h_q;
    total_prod = PROD_W'(w_new) * PROD_W'(h_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_COPY;
      w_q     <= DIM_W'(RST_DIM);
      h_q     <= DIM_W'(RST_DIM);
      total_q <= CNT_W'(RST_DIM * RST_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q <= mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_WIDTH:  w_q    <= w_new;
        CFG_HEIGHT: h_q    <= h_new;
        default: ;
      endcase
      total_q <= CNT_W'(total_prod);
    end
  end

  // ---------------------------------------------------------------------------
  // Input acceptance, frame fill and read position.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] load_count_q, load_count_d;
  logic [POS_W-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic             s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic             en1, en2, en3, en4;
  logic             hazard, in_acc, rd_acc, ld_we, issue, clear;
  logic             rotated, full, in_range, is_last;
  logic [DIM_W-1:0] ow, oh, row_ext, col_ext, w_m1, h_m1, sr, sc, w_rc, h_rr;

  assign en4 = !out_v_q || !out_stall_i;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;

  // Once a frame is cleared, new loads must not overwrite entries that reads
  // still in flight have yet to fetch.
  assign hazard     = (load_count_q == '0) && (s1_v_q || s2_v_q);
  assign in_stall_o = !en1 || hazard;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    rotated  = (mode_q == MODE_ROT_CW) || (mode_q == MODE_ROT_CCW);
    ow       = rotated ? h_q : w_q;
    oh       = rotated ? w_q : h_q;
    row_ext  = DIM_W'(out_row_q);
    col_ext  = DIM_W'(out_col_q);
    w_m1     = w_q - DIM_W'(1);
    h_m1     = h_q - DIM_W'(1);
    w_rc     = w_m1 - col_ext;
    h_rr     = h_m1 - row_ext;
    full     = load_count_q >= total_q;
    in_range = (row_ext < oh) && (col_ext < ow);
    is_last  = (row_ext == oh - DIM_W'(1)) && (col_ext == ow - DIM_W'(1));

    case (mode_q)
      MODE_FLIP: begin
        sr = h_rr;
        sc = col_ext;
      end
      MODE_ROT_CW: begin
        sr = h_m1 - col_ext;
        sc = row_ext;
      end
      MODE_ROT_CCW: begin
        sr = col_ext;
        sc = w_m1 - row_ext;
      end
      MODE_MIRROR_LR: begin
        sr = row_ext;
        sc = (col_ext < w_rc) ? col_ext : w_rc;
      end
      MODE_MIRROR_TB: begin
        sr = (row_ext < h_rr) ? row_ext : h_rr;
        sc = col_ext;
      end
      default: begin
        sr = row_ext;
        sc = col_ext;
      end
    endcase

    rd_acc = in_acc && (action_i == ACT_READ);
    ld_we  = in_acc && (action_i == ACT_LOAD) && !full;
    issue  = rd_acc && full && in_range;
    // A read at the final position, or at a position left stale by a register
    // change, ends the frame.
    clear  = rd_acc && full && (!in_range || is_last);

    load_count_d = load_count_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    if (clear) begin
      load_count_d = '0;
      out_row_d    = '0;
      out_col_d    = '0;
    end else if (issue) begin
      if (col_ext + DIM_W'(1) >= ow) begin
        out_col_d = '0;
        out_row_d = out_row_q + POS_W'(1);
      end else begin
        out_col_d = out_col_q + POS_W'(1);
      end
    end else if (ld_we) begin
      load_count_d = load_count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
    end else begin
      load_count_q <= load_count_d;
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Read pipeline: source position, address, memory read, pixel transform.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] s1_sr_q, s1_sc_q;
  logic             s1_last_q, s2_last_q, s3_last_q, out_last_q;
  logic [CNT_W-1:0] addr_full;
  logic [AW-1:0]    s2_addr_q;
  pixel_t           rdata_q, out_px_q, px_d;
  pixel_t           mem [DEPTH];
  logic [GRAY_SUM_W-1:0] gray_sum;

  assign addr_full = CNT_W'(s1_sr_q) * CNT_W'(w_q) + CNT_W'(s1_sc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q  <= issue;
      if (en2) s2_v_q  <= s1_v_q;
      if (en3) s3_v_q  <= s2_v_q;
      if (en4) out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && issue) begin
      s1_sr_q   <= sr[POS_W-1:0];
      s1_sc_q   <= sc[POS_W-1:0];
      s1_last_q <= is_last;
    end
    if (en2) begin
      s2_addr_q <= addr_full[AW-1:0];
      s2_last_q <= s1_last_q;
    end
    if (en3) begin
      s3_last_q <= s2_last_q;
    end
    if (en4) begin
      out_px_q   <= px_d;
      out_last_q <= s3_last_q;
    end
  end

  // Frame memory: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      mem[load_count_q[AW-1:0]] <= '{red: in_red_i, green: in_green_i, blue: in_blue_i};
    end
    if (en3) begin
      rdata_q <= mem[s2_addr_q];
    end
  end

  always_comb begin
    gray_sum = GRAY_SUM_W'(GRAY_R_COEF) * GRAY_SUM_W'(rdata_q.red)
             + GRAY_SUM_W'(GRAY_G_COEF) * GRAY_SUM_W'(rdata_q.green)
             + GRAY_SUM_W'(GRAY_B_COEF) * GRAY_SUM_W'(rdata_q.blue);
    case (mode_q)
      MODE_GRAY: begin
        px_d.red   = gray_sum[GRAY_SUM_W-1 -: CHAN_W];
        px_d.green = gray_sum[GRAY_SUM_W-1 -: CHAN_W];
        px_d.blue  = gray_sum[GRAY_SUM_W-1 -: CHAN_W];
      end
      MODE_NEGATIVE: begin
        px_d.red   = ~rdata_q.red;
        px_d.green = ~rdata_q.green;
        px_d.blue  = ~rdata_q.blue;
      end
      default: px_d = rdata_q;
    endcase
  end

  assign out_valid_o  = out_v_q;
  assign out_red_o    = out_px_q.red;
  assign out_green_o  = out_px_q.green;
  assign out_blue_o   = out_px_q.blue;
  assign last_pixel_o = out_last_q;

endmodule

>>> sv/frfe_checker.sv
// Port-level checker for the frame rotate/flip engine, bound to the top level.
// Depends on frfe_pkg and the assertion macros header.
`include "frame_rotate_flip_engine_top_macros.svh"

module frfe_checker
  import frfe_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              action_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CHAN_W-1:0] out_red_o,
  input logic [CHAN_W-1:0] out_green_o,
  input logic [CHAN_W-1:0] out_blue_o,
  input logic              last_pixel_o
);

  logic              out_held;
  logic              rd_acc;
  logic [3*CHAN_W:0] out_word;

  assign out_held = out_valid_o && out_stall_i;
  assign rd_acc   = in_valid_i && !in_stall_o && (action_i == ACT_READ);
  assign out_word = {out_red_o, out_green_o, out_blue_o, last_pixel_o};

  `FRFE_ASSERT_NEXT(a_out_valid_hold, out_held, out_valid_o, "output transaction dropped")
  `FRFE_ASSERT_NEXT(a_out_payload_hold, out_held, $stable(out_word), "output payload changed")
  // With the output empty, a pixel flows through the pipeline without waiting,
  // so a fresh output always traces back to a read sampled as it entered the pipeline.
  `FRFE_ASSERT_NOW(a_out_from_read, $rose(out_valid_o), $past(rd_acc, 4), "output without a read")

endmodule

bind frame_rotate_flip_engine_top frfe_checker u_frfe_checker (.*);

>>> tb/sv/frame_rotate_flip_engine_top_tb.sv
// Self-checking testbench for the frame rotate/flip engine: directed and random pixel streams.
// Depends on frfe_pkg and frame_rotate_flip_engine_top; predicts every output pixel on its own.
module frame_rotate_flip_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frfe_pkg::*;

  localparam int unsigned MAX_DIM       = 256;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS  = 640;
  localparam longint unsigned TIMEOUT_NS = 64'd1_000_000;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    pixel_t px;
    logic   last;
  } frame_out_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [CHAN_W-1:0]     in_red_i;
  logic [CHAN_W-1:0]     in_green_i;
  logic [CHAN_W-1:0]     in_blue_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CHAN_W-1:0]     out_red_o;
  logic [CHAN_W-1:0]     out_green_o;
  logic [CHAN_W-1:0]     out_blue_o;
  logic                  last_pixel_o;

  // Shadow copy of the engine state and registers.
  pixel_t                pix_mem [0:MAX_DIM*MAX_DIM-1];
  int unsigned           fill_count;
  int unsigned           rd_row;
  int unsigned           rd_col;
  mode_e                 cur_mode;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;

  frame_out_t  expected_pixels[$];
  frame_out_t  want;
  int unsigned error_count;
  int unsigned useful_items;
  int unsigned burst_left;
  int unsigned stall_left;
  int unsigned stall_pct;

  frame_rotate_flip_engine_top #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .last_pixel_o(last_pixel_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned clamped_dim(logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_total();
    return clamped_dim(width_reg) * clamped_dim(height_reg);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px = pixel_t'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(9, 16));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Applies one accepted pixel transaction to the shadow state and queues any output pixel.
  task automatic transform_pixel_op(input logic act, input pixel_t px_in, output logic effective);
    int unsigned w, h, ow, oh, sr, sc;
    logic        rotated;
    logic [31:0] luma;
    pixel_t      px;
    w = clamped_dim(width_reg);
    h = clamped_dim(height_reg);
    effective = 1'b0;
    if (act == ACT_LOAD) begin
      if (fill_count < w * h) begin
        pix_mem[fill_count] = px_in;
        fill_count++;
        effective = 1'b1;
      end
      return;
    end
    if (fill_count < w * h) return;
    rotated = (cur_mode == MODE_ROT_CW) || (cur_mode == MODE_ROT_CCW);
    ow = rotated ? h : w;
    oh = rotated ? w : h;
    // A register change during readout can leave the position outside the new frame.
    if (rd_row >= oh || rd_col >= ow) begin
      fill_count = 0;
      rd_row = 0;
      rd_col = 0;
      return;
    end
    case (cur_mode)
      MODE_FLIP: begin
        sr = h - 1 - rd_row;
        sc = rd_col;
      end
      MODE_ROT_CW: begin
        sr = h - 1 - rd_col;
        sc = rd_row;
      end
      MODE_ROT_CCW: begin
        sr = rd_col;
        sc = w - 1 - rd_row;
      end
      MODE_MIRROR_LR: begin
        sr = rd_row;
        sc = (rd_col < w - 1 - rd_col) ? rd_col : w - 1 - rd_col;
      end
      MODE_MIRROR_TB: begin
        sr = (rd_row < h - 1 - rd_row) ? rd_row : h - 1 - rd_row;
        sc = rd_col;
      end
      default: begin
        sr = rd_row;
        sc = rd_col;
      end
    endcase
    px = pix_mem[sr * w + sc];
    if (cur_mode == MODE_GRAY) begin
      luma = 32'(GRAY_R_COEF) * 32'(px.red) + 32'(GRAY_G_COEF) * 32'(px.green)
           + 32'(GRAY_B_COEF) * 32'(px.blue);
      px.red   = luma[23:16];
      px.green = luma[23:16];
      px.blue  = luma[23:16];
    end else if (cur_mode == MODE_NEGATIVE) begin
      px.red   = ~px.red;
      px.green = ~px.green;
      px.blue  = ~px.blue;
    end
    effective = 1'b1;
    if (rd_row == oh - 1 && rd_col == ow - 1) begin
      expected_pixels.push_back('{px: px, last: 1'b1});
      fill_count = 0;
      rd_row = 0;
      rd_col = 0;
    end else begin
      expected_pixels.push_back('{px: px, last: 1'b0});
      if (rd_col + 1 >= ow) begin
        rd_col = 0;
        rd_row++;
      end else begin
        rd_col++;
      end
    end
  endtask

  // Sends one pixel transaction; valid stays high within a burst.
  task automatic send_pixel_op(input logic act, input pixel_t px);
    int unsigned gap;
    logic        effective;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i   <= act;
    in_red_i   <= px.red;
    in_green_i <= px.green;
    in_blue_i  <= px.blue;
    do @(posedge clk_i); while (in_stall_o);
    transform_pixel_op(act, px, effective);
    if (effective) useful_items++;
    @(negedge clk_i);
  endtask

  // Stops the input, waits for every predicted pixel, then lets the pipeline settle.
  task automatic wait_frame_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MODE:   cur_mode = mode_e'(data[MODE_W-1:0]);
      CFG_WIDTH:  width_reg = data;
      CFG_HEIGHT: height_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Loads until the frame is full and reads until it clears; cut, when nonzero, is the read
  // after which one register is rewritten in the middle of readout.
  task automatic run_frame(input int unsigned cut);
    int unsigned reads;
    reads = 0;
    do begin
      while (fill_count < frame_total()) begin
        if ($urandom_range(0, 15) == 0) send_pixel_op(ACT_READ, random_pixel());
        send_pixel_op(ACT_LOAD, random_pixel());
      end
      if ($urandom_range(0, 7) == 0) send_pixel_op(ACT_LOAD, random_pixel());
      while (fill_count != 0 && fill_count >= frame_total()) begin
        send_pixel_op(ACT_READ, random_pixel());
        reads++;
        if (reads == cut) begin
          wait_frame_idle();
          case ($urandom_range(0, 2))
            0: write_register(CFG_MODE, CFG_DATA_W'($urandom));
            1: write_register(CFG_WIDTH, random_dim());
            default: write_register(CFG_HEIGHT, random_dim());
          endcase
        end
      end
    end while (fill_count != 0);
    if ($urandom_range(0, 5) == 0) send_pixel_op(ACT_READ, random_pixel());
  endtask

  // Default 256x256 size after reset, then a shrink that makes a partial load a full frame.
  task automatic test_reset_state();
    send_pixel_op(ACT_READ, '0);
    send_pixel_op(ACT_LOAD, 24'hFF0055);
    send_pixel_op(ACT_LOAD, 24'h00FFAA);
    send_pixel_op(ACT_LOAD, 24'h123456);
    send_pixel_op(ACT_READ, '0);
    wait_frame_idle();
    write_register(CFG_WIDTH, 9'd1);
    write_register(CFG_HEIGHT, 9'd1);
    send_pixel_op(ACT_READ, '0);
    send_pixel_op(ACT_READ, '0);
  endtask

  task automatic test_special_cases();
    wait_frame_idle();
    // Zero dimensions act as one; the unused index must not disturb anything.
    write_register(CFG_MODE, CFG_DATA_W'(MODE_GRAY));
    write_register(CFG_WIDTH, 9'd0);
    write_register(CFG_HEIGHT, 9'd0);
    write_register(CFG_UNUSED, 9'h1FF);
    send_pixel_op(ACT_LOAD, 24'hFFFFFF);
    send_pixel_op(ACT_LOAD, 24'h000000);
    send_pixel_op(ACT_READ, '0);
    send_pixel_op(ACT_LOAD, 24'h8040C0);
    send_pixel_op(ACT_READ, '0);
    wait_frame_idle();
    write_register(CFG_MODE, CFG_DATA_W'(MODE_NEGATIVE));
    write_register(CFG_WIDTH, 9'd2);
    write_register(CFG_HEIGHT, 9'd1);
    send_pixel_op(ACT_LOAD, 24'h000000);
    send_pixel_op(ACT_LOAD, 24'hFFFFFF);
    send_pixel_op(ACT_READ, '0);
    send_pixel_op(ACT_READ, '0);
    send_pixel_op(ACT_READ, '0);
    wait_frame_idle();
    // Narrowing the frame mid-readout strands the read position outside it.
    write_register(CFG_MODE, CFG_DATA_W'(MODE_COPY));
    write_register(CFG_HEIGHT, 9'd2);
    send_pixel_op(ACT_LOAD, 24'hA5A5A5);
    send_pixel_op(ACT_LOAD, 24'h5A5A5A);
    send_pixel_op(ACT_LOAD, 24'h0F0F0F);
    send_pixel_op(ACT_LOAD, 24'hF0F0F0);
    send_pixel_op(ACT_READ, '0);
    wait_frame_idle();
    write_register(CFG_WIDTH, 9'd1);
    send_pixel_op(ACT_READ, '0);
    send_pixel_op(ACT_READ, '0);
  endtask

  // A width past the maximum clamps to 256; rotated, the frame reads out as 256 rows.
  task automatic test_size_extremes();
    wait_frame_idle();
    write_register(CFG_MODE, CFG_DATA_W'(MODE_ROT_CW));
    write_register(CFG_WIDTH, 9'h1FF);
    write_register(CFG_HEIGHT, 9'd1);
    run_frame(0);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned cut;
    start = useful_items;
    while (useful_items - start < RANDOM_ITEMS) begin
      wait_frame_idle();
      write_register(CFG_MODE, CFG_DATA_W'($urandom));
      write_register(CFG_WIDTH, random_dim());
      write_register(CFG_HEIGHT, random_dim());
      if ($urandom_range(0, 9) == 0) write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
      cut = 0;
      if (frame_total() > 1 && $urandom_range(0, 3) == 0) cut = $urandom_range(1, frame_total() - 1);
      run_frame(cut);
    end
  endtask

  // Output stall follows its own pattern: segments of no, light, medium and heavy backpressure.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 160);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_left--;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        $display("%0t: unexpected output pixel: expected none, actual %h %h %h last %b", $time,
                 out_red_o, out_green_o, out_blue_o, last_pixel_o);
      end else begin
        want = expected_pixels.pop_front();
        if ({out_red_o, out_green_o, out_blue_o, last_pixel_o} !== want) begin
          error_count++;
          if (out_red_o !== want.px.red)
            $display("%0t: red mismatch: expected %h, actual %h", $time,
                     want.px.red, out_red_o);
          if (out_green_o !== want.px.green)
            $display("%0t: green mismatch: expected %h, actual %h", $time,
                     want.px.green, out_green_o);
          if (out_blue_o !== want.px.blue)
            $display("%0t: blue mismatch: expected %h, actual %h", $time,
                     want.px.blue, out_blue_o);
          if (last_pixel_o !== want.last)
            $display("%0t: last_pixel mismatch: expected %b, actual %b", $time,
                     want.last, last_pixel_o);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("frame_rotate_flip_engine_top regression: fail");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MODE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    action_i    = ACT_LOAD;
    in_red_i    = '0;
    in_green_i  = '0;
    in_blue_i   = '0;
    out_stall_i = 1'b0;
    stall_left  = 0;
    stall_pct   = 0;
    burst_left  = 0;
    error_count = 0;
    useful_items = 0;
    fill_count  = 0;
    rd_row      = 0;
    rd_col      = 0;
    cur_mode    = MODE_COPY;
    width_reg   = CFG_DATA_W'(CFG_DIM_RESET);
    height_reg  = CFG_DATA_W'(CFG_DIM_RESET);
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_special_cases();
    test_size_extremes();
    test_random_frames();
    wait_frame_idle();

    if (error_count == 0) begin
      $display("frame_rotate_flip_engine_top regression: pass");
    end else begin
      $display("frame_rotate_flip_engine_top regression: fail");
    end
    $finish;
  end

endmodule
